FILE: rtl/bara_pkg.sv
// shared types, constants and helpers for the button autorepeat unit
package bara_pkg;

  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned NUM_REGS    = 5;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 3;

  localparam logic [NUM_BUTTONS-1:0] SELECT_MASK = NUM_BUTTONS'(1) << 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_RIGHT  = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_UP     = 3'd2,
    CMD_DOWN   = 3'd3,
    CMD_SELECT = 3'd4
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_INTERVAL_FIRST  = 3'd0,
    REG_INTERVAL_SECOND = 3'd1,
    REG_INTERVAL_THIRD  = 3'd2,
    REG_THRESHOLD_2ND   = 3'd3,
    REG_THRESHOLD_3RD   = 3'd4
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_INTERVAL_FIRST  = 16'd500;
  localparam logic [CFG_W-1:0] RST_INTERVAL_SECOND = 16'd200;
  localparam logic [CFG_W-1:0] RST_INTERVAL_THIRD  = 16'd50;
  localparam logic [CFG_W-1:0] RST_THRESHOLD_2ND   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_THRESHOLD_3RD   = 16'd3000;

  typedef struct packed {
    logic [CFG_W-1:0] interval_first;
    logic [CFG_W-1:0] interval_second;
    logic [CFG_W-1:0] interval_third;
    logic [CFG_W-1:0] threshold_second;
    logic [CFG_W-1:0] threshold_third;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic [CMD_W-1:0]     command;
  } result_t;

  function automatic logic [CMD_W-1:0] code_of(input logic [NUM_BUTTONS-1:0] onehot);
    logic [CMD_W-1:0] c;
    c = CMD_RIGHT;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (onehot[i]) begin
        c = CMD_W'(i);
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/bara_cfg_regs.sv
// apb configuration register file for the repeat intervals and hold thresholds
module bara_cfg_regs
  import bara_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic           wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_first   <= RST_INTERVAL_FIRST;
      cfg.interval_second  <= RST_INTERVAL_SECOND;
      cfg.interval_third   <= RST_INTERVAL_THIRD;
      cfg.threshold_second <= RST_THRESHOLD_2ND;
      cfg.threshold_third  <= RST_THRESHOLD_3RD;
    end else if (wr_en) begin
      unique case (idx)
        REG_INTERVAL_FIRST:  cfg.interval_first   <= pwdata[CFG_W-1:0];
        REG_INTERVAL_SECOND: cfg.interval_second  <= pwdata[CFG_W-1:0];
        REG_INTERVAL_THIRD:  cfg.interval_third   <= pwdata[CFG_W-1:0];
        REG_THRESHOLD_2ND:   cfg.threshold_second <= pwdata[CFG_W-1:0];
        REG_THRESHOLD_3RD:   cfg.threshold_third  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_INTERVAL_FIRST:  prdata = DATA_W'(cfg.interval_first);
      REG_INTERVAL_SECOND: prdata = DATA_W'(cfg.interval_second);
      REG_INTERVAL_THIRD:  prdata = DATA_W'(cfg.interval_third);
      REG_THRESHOLD_2ND:   prdata = DATA_W'(cfg.threshold_second);
      REG_THRESHOLD_3RD:   prdata = DATA_W'(cfg.threshold_third);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bara_core.sv
// input register, hold state and single-pass repeat decision
module bara_core
  import bara_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_BUTTONS-1:0] buttons,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic                   out_free,
  output result_t                result
);

  logic                   s1_valid;
  logic [NUM_BUTTONS-1:0] s1_buttons;
  logic [TIME_W-1:0]      s1_now;

  logic [NUM_BUTTONS-1:0] held_button;
  logic [NUM_BUTTONS-1:0] held_button_next;
  logic [TIME_W-1:0]      press_time;
  logic [TIME_W-1:0]      press_time_next;
  logic [TIME_W-1:0]      last_emit_time;
  logic [TIME_W-1:0]      last_emit_time_next;

  logic                   clear;
  logic                   fresh;
  logic [TIME_W-1:0]      press_eff;
  logic [TIME_W-1:0]      last_eff;
  logic [TIME_W-1:0]      hold;
  logic [TIME_W-1:0]      elapsed;
  logic [CFG_W-1:0]       interval;
  logic                   slot;
  logic                   emit;
  logic                   s1_move;
  logic                   in_accept;

  assign clear = !$onehot(s1_buttons) ||
                 ((held_button != '0) && ((s1_buttons & held_button) == '0));
  assign fresh     = (held_button == '0);
  assign press_eff = fresh ? s1_now : press_time;
  assign last_eff  = fresh ? s1_now : last_emit_time;
  assign hold      = s1_now - press_eff;
  assign elapsed   = s1_now - last_eff;

  always_comb begin
    priority if (hold > TIME_W'(cfg.threshold_third)) begin
      interval = cfg.interval_third;
    end else if (hold > TIME_W'(cfg.threshold_second)) begin
      interval = cfg.interval_second;
    end else begin
      interval = cfg.interval_first;
    end
  end

  assign slot = elapsed > TIME_W'(interval);
  assign emit = !clear && (fresh || (slot && (s1_buttons != SELECT_MASK)));

  assign s1_move   = s1_valid && (!emit || out_free);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  assign result.load    = s1_move && emit;
  assign result.command = code_of(s1_buttons);

  always_comb begin
    held_button_next    = held_button;
    press_time_next     = press_time;
    last_emit_time_next = last_emit_time;
    if (s1_move) begin
      if (clear) begin
        held_button_next    = '0;
        press_time_next     = '0;
        last_emit_time_next = '0;
      end else begin
        held_button_next    = s1_buttons;
        press_time_next     = press_eff;
        last_emit_time_next = slot ? s1_now : last_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      held_button    <= '0;
      press_time     <= '0;
      last_emit_time <= '0;
    end else begin
      s1_valid       <= in_accept || (s1_valid && !s1_move);
      held_button    <= held_button_next;
      press_time     <= press_time_next;
      last_emit_time <= last_emit_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_buttons <= buttons;
      s1_now     <= now_ms;
    end
  end

endmodule

FILE: rtl/bara_out_stage.sv
// result register holding one command until the consumer takes it
module bara_out_stage
  import bara_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  result_t          result,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CMD_W-1:0] command
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      command <= result.command;
    end
  end

endmodule

FILE: rtl/button_autorepeat_accelerating_unit.sv
// top level of the accelerating button autorepeat unit
// an accepted poll is registered in the input stage, and its result is then loaded into the result register
// throughput: one poll per cycle; an emitting poll waits only while the result register is full and stalled
// a poll that emits nothing passes the held result register without waiting
// reset clears the held button, both timestamps and the pipeline, and restores register defaults
module button_autorepeat_accelerating_unit
  import bara_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_BUTTONS-1:0] buttons,
  input  logic [TIME_W-1:0]      now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CMD_W-1:0]       command
);

  cfg_t    cfg;
  result_t result;
  logic    out_free;

  bara_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bara_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .buttons  (buttons),
    .now_ms   (now_ms),
    .out_free (out_free),
    .result   (result)
  );

  bara_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command)
  );

endmodule

FILE: rtl/bara_checker.sv
// port-level checks for the autorepeat unit and their binding
module bara_checker
  import bara_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CMD_W-1:0] command
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command))
    else $error("stalled result transaction changed");

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command <= CMD_SELECT)
    else $error("command code out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rise_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a poll transaction two cycles earlier");

endmodule

bind button_autorepeat_accelerating_unit bara_checker u_bara_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .command   (command)
);
